// File: design/floyd_steinberg_rgb565_dither_assert.svh
// Assertion macros shared by the dither RTL.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef FLOYD_STEINBERG_RGB565_DITHER_ASSERT_SVH
`define FLOYD_STEINBERG_RGB565_DITHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSD_CHECK(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dither check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSD_CHECK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dither check failed");

`endif

// File: design/fsd_pkg.sv
// Shared types, constants and arithmetic helpers for the RGB565 dither.
// No dependencies; used by the front, queue, back end and top level.
`default_nettype none

package fsd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ERR_W     = 26;
	localparam int PRE_W     = ERR_W + 1;
	localparam int SUM_W     = ERR_W + 2;
	localparam int SH_W      = ERR_W + 3;
	localparam int CFG_W     = 16;
	localparam int WIDTH_W   = 12;
	localparam int HEIGHT_W  = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

	// error shares in sixteenths
	localparam int SHARE_DIV   = 16;
	localparam int SHARE_SHIFT = $clog2(SHARE_DIV);
	localparam logic [3:0] W_RIGHT      = 4'd7;
	localparam logic [3:0] W_BELOW_LEFT = 4'd3;
	localparam logic [3:0] W_BELOW      = 4'd5;
	localparam logic [3:0] W_BELOW_RT   = 4'd1;

	typedef logic signed [ERR_W-1:0] fsd_err_t;

	localparam fsd_err_t TOP_RB = fsd_err_t'(ERR_W'(8'hf8) << FRAC_BITS);
	localparam fsd_err_t TOP_G  = fsd_err_t'(ERR_W'(8'hfc) << FRAC_BITS);

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} fsd_reg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} fsd_rgb_t;

	typedef struct packed {
		logic first_row;
		logic last_row;
		logic last_col;
	} fsd_flags_t;

	typedef struct packed {
		logic [5:0] code;
		fsd_err_t   qe;
	} fsd_quant_t;

	// clamp to the signed error range
	function automatic fsd_err_t fsd_sat(input logic signed [SUM_W-1:0] v);
		logic fits;
		fits = (&v[SUM_W-1:ERR_W-1]) || !(|v[SUM_W-1:ERR_W-1]);
		if (fits)
			return v[ERR_W-1:0];
		else if (v[SUM_W-1])
			return {1'b1, {(ERR_W-1){1'b0}}};
		else
			return {1'b0, {(ERR_W-1){1'b1}}};
	endfunction

	// truncating quantizer; wide selects the 6-bit green code
	function automatic fsd_quant_t fsd_quant(input fsd_err_t old, input logic wide);
		fsd_err_t   top;
		fsd_err_t   nw;
		fsd_quant_t r;
		top = wide ? TOP_G : TOP_RB;
		if (old > top)
			nw = top;
		else if (old > 0)
			nw = old & top;
		else
			nw = '0;
		r.code = wide ? nw[FRAC_BITS+7 -: 6] : {1'b0, nw[FRAC_BITS+7 -: 5]};
		r.qe   = old - nw;
		return r;
	endfunction

	// floor(qe * k / 16)
	function automatic fsd_err_t fsd_share(input fsd_err_t qe, input logic [3:0] k);
		logic signed [SH_W-1:0] a;
		logic signed [SH_W-1:0] b;
		logic signed [SH_W-1:0] p;
		a = SH_W'(qe);
		b = SH_W'(k);
		p = a * b;
		return ERR_W'(p >>> SHARE_SHIFT);
	endfunction

endpackage

`default_nettype wire

// File: design/fsd_front.sv
// Front end: configuration registers, raster counters, per-pixel flags.
// Uses fsd_pkg; feeds fsd_queue.
`default_nettype none

module fsd_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [fsd_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        pix_valid,
	input  wire logic                        full,
	output logic                             push,
	output logic [$clog2(MAX_WIDTH)-1:0]     col,
	output fsd_pkg::fsd_flags_t              flags
);
	import fsd_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CW = ((WW > WIDTH_W) ? WW : WIDTH_W) + 1;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [XW-1:0]       col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [CW-1:0]       w_cfg;
	logic [CW-1:0]       w_eff;
	logic [CW-1:0]       col_p1;
	logic [HEIGHT_W-1:0] h_eff;
	logic [HEIGHT_W:0]   row_p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_cfg  = CW'(width_q);
		if (w_cfg == '0)
			w_eff = CW'(1);
		else if (w_cfg > CW'(MAX_WIDTH))
			w_eff = CW'(MAX_WIDTH);
		else
			w_eff = w_cfg;
		col_p1 = CW'(col_q) + CW'(1);
		h_eff  = (height_q == '0) ? HEIGHT_W'(1) : height_q;
		row_p1 = (HEIGHT_W+1)'(row_q) + (HEIGHT_W+1)'(1);
		flags.first_row = (row_q == '0);
		flags.last_row  = (row_p1 >= (HEIGHT_W+1)'(h_eff));
		flags.last_col  = (col_p1 >= w_eff);
	end

	assign push = pix_valid && !full;
	assign col  = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (flags.last_col) begin
				col_q <= '0;
				row_q <= flags.last_row ? '0 : row_p1[HEIGHT_W-1:0];
			end else begin
				col_q <= col_p1[XW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: design/fsd_queue.sv
// Short register queue between the front end and the back end.
// Uses fsd_pkg for its depth.
`default_nettype none

module fsd_queue #(
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          pop,
	output logic               full,
	output logic               nonempty,
	output logic [DW-1:0]      rdata
);
	import fsd_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic [DW-1:0] slot_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign full     = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + AW'(1);
			if (pop)
				rd_q <= rd_q + AW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/fsd_back.sv
// Back end: line buffer, error diffusion pipeline and output register.
// Uses fsd_pkg and the assertion macro header.
`default_nettype none
`include "floyd_steinberg_rgb565_dither_assert.svh"

module fsd_back #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         head_valid,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] head_col,
	input  wire fsd_pkg::fsd_flags_t          head_flags,
	input  wire fsd_pkg::fsd_rgb_t            head_rgb,
	output logic                              pop,
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output logic [15:0]                       pixel_565,
	output logic                              row_end,
	output logic                              frame_end
);
	import fsd_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int MW = 3 * ERR_W;

	// line buffer: one entry per column, three channel errors
	logic [MW-1:0] mem [MAX_WIDTH];

	logic          en;
	logic          hazard;

	logic          v_s1, v_s2, v_s3;
	logic [XW-1:0] x_s1, x_s2, x_s3;
	fsd_flags_t    f_s1, f_s2, f_s3;
	fsd_rgb_t      rgb_s1;
	logic [MW-1:0] rd_s1;

	logic signed [PRE_W-1:0] pre   [3];
	logic signed [PRE_W-1:0] pre_s2[3];
	fsd_err_t   right_q [3];
	fsd_err_t   right_d [3];
	fsd_quant_t qz      [3];
	fsd_err_t   qe_s3   [3];
	fsd_err_t   near_q  [3];
	fsd_err_t   far_q   [3];
	fsd_err_t   new_near[3];
	logic [7:0] chan_in [3];

	logic          bl_wr;
	logic          set_pend;
	logic [MW-1:0] wd_left;
	logic [MW-1:0] wd_pend;
	logic          mem_we;
	logic [XW-1:0] wa;
	logic [MW-1:0] wd;

	logic          pend_v_q;
	logic [XW-1:0] pend_a_q;
	logic [MW-1:0] pend_d_q;

	logic          res_valid_q;
	logic [15:0]   pixel_q;
	logic          row_end_q;
	logic          frame_end_q;

	// does an in-flight item still have a line buffer write to address a
	function automatic logic writes_to(input logic v, input logic [XW-1:0] x,
			input fsd_flags_t f, input logic [XW-1:0] a);
		logic left;
		logic here;
		left = (x != '0) && (XW'(x - XW'(1)) == a);
		here = f.last_col && (x == a);
		return v && !f.last_row && (left || here);
	endfunction

	assign en = !res_valid_q || !res_stall;

	always_comb begin
		hazard = !head_flags.first_row && (
			writes_to(v_s1, x_s1, f_s1, head_col) ||
			writes_to(v_s2, x_s2, f_s2, head_col) ||
			writes_to(v_s3, x_s3, f_s3, head_col) ||
			(pend_v_q && (pend_a_q == head_col)));
	end

	assign pop = en && head_valid && !hazard;

	// issue: read the line buffer for this column
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wa] <= wd;
		if (en)
			rd_s1 <= mem[head_col];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= head_col;
			f_s1   <= head_flags;
			rgb_s1 <= head_rgb;
			x_s2   <= x_s1;
			f_s2   <= f_s1;
			x_s3   <= x_s2;
			f_s3   <= f_s2;
			for (int c = 0; c < 3; c++) begin
				pre_s2[c] <= pre[c];
				qe_s3[c]  <= qz[c].qe;
			end
		end
	end

	// stage 1: source value plus error from the row above
	always_comb begin
		chan_in[0] = rgb_s1.red;
		chan_in[1] = rgb_s1.green;
		chan_in[2] = rgb_s1.blue;
		for (int c = 0; c < 3; c++) begin
			pre[c] = PRE_W'({chan_in[c], {FRAC_BITS{1'b0}}});
			if (!f_s1.first_row)
				pre[c] = pre[c] + PRE_W'(fsd_err_t'(rd_s1[c*ERR_W +: ERR_W]));
		end
	end

	// stage 2: right-neighbor carry loop, quantize
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qz[c]      = fsd_quant(fsd_sat(SUM_W'(pre_s2[c]) + SUM_W'(right_q[c])), c == 1);
			right_d[c] = f_s2.last_col ? '0 : fsd_share(qz[c].qe, W_RIGHT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++)
				right_q[c] <= '0;
		end else if (en && v_s2) begin
			for (int c = 0; c < 3; c++)
				right_q[c] <= right_d[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (en)
			res_valid_q <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_q     <= {qz[0].code[4:0], qz[1].code, qz[2].code[4:0]};
			row_end_q   <= f_s2.last_col;
			frame_end_q <= f_s2.last_col && f_s2.last_row;
		end
	end

	// stage 3: below-row shares gathered into the next row's entries
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			new_near[c] = far_q[c] + fsd_share(qe_s3[c], W_BELOW);
			wd_left[c*ERR_W +: ERR_W] = near_q[c] + fsd_share(qe_s3[c], W_BELOW_LEFT);
			wd_pend[c*ERR_W +: ERR_W] = new_near[c];
		end
		bl_wr    = en && v_s3 && !f_s3.last_row && (x_s3 != '0);
		set_pend = en && v_s3 && !f_s3.last_row && f_s3.last_col;
		mem_we   = bl_wr || (en && pend_v_q);
		wa       = bl_wr ? XW'(x_s3 - XW'(1)) : pend_a_q;
		wd       = bl_wr ? wd_left : pend_d_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				near_q[c] <= '0;
				far_q[c]  <= '0;
			end
		end else if (en && v_s3) begin
			for (int c = 0; c < 3; c++) begin
				if (f_s3.last_col) begin
					near_q[c] <= '0;
					far_q[c]  <= '0;
				end else if (!f_s3.last_row) begin
					near_q[c] <= new_near[c];
					far_q[c]  <= fsd_share(qe_s3[c], W_BELOW_RT);
				end
			end
		end
	end

	// last column entry waits in a pending register for a free write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_v_q <= 1'b0;
		else if (set_pend)
			pend_v_q <= 1'b1;
		else if (en && !bl_wr)
			pend_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (set_pend) begin
			pend_a_q <= x_s3;
			pend_d_q <= wd_pend;
		end
	end

	assign res_valid = res_valid_q;
	assign pixel_565 = pixel_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

	`FSD_CHECK(a_pend_no_clobber, clk, arst_n, set_pend && bl_wr, !pend_v_q)
	`FSD_CHECK(a_read_not_racing, clk, arst_n, pop && !head_flags.first_row && mem_we,
		wa != head_col)
	`FSD_CHECK_NEXT(a_carry_cleared, clk, arst_n, en && v_s3 && f_s3.last_col,
		near_q[0] == '0 && far_q[0] == '0 && near_q[2] == '0 && far_q[2] == '0)
	`FSD_CHECK(a_frame_ends_row, clk, arst_n, res_valid && frame_end, row_end)

endmodule

`default_nettype wire

// File: design/floyd_steinberg_rgb565_dither.sv
// Floyd-Steinberg dither, RGB888 pixel stream in, RGB565 pixel stream out.
// Channels: pix (red_in, green_in, blue_in) in raster order, moved on
//   pix_valid && !pix_stall; res (pixel_565, row_end, frame_end), one word
//   per pixel, moved on res_valid && !res_stall. Words leave in input order.
// Config: cfg_we writes cfg_data into register cfg_index at the clock edge:
//   0 = image_width (1..MAX_WIDTH used), 1 = image_height (0 counts as 1).
//   Write only while no pixel is in flight.
// Throughput: one pixel per clock while the receiver does not stall. Images
//   narrower than five pixels run slower: a pixel reading the line
//   buffer waits for the previous row's write to that column to land.
// Path: queue, then stage 1, stage 2 and the output word register to res_valid.
// Reset: width 640, height 480, counters at the frame origin, carried
//   errors zero. The line buffer is not cleared; the first row ignores it.
// Receiver stall: the output word holds, the back pipeline freezes and the
//   four-word queue keeps taking pixels until full, then pix_stall rises.
`default_nettype none

module floyd_steinberg_rgb565_dither #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [fsd_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                       pix_valid,
	output logic                            pix_stall,
	input  wire logic [7:0]                 red_in,
	input  wire logic [7:0]                 green_in,
	input  wire logic [7:0]                 blue_in,
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output logic [15:0]                     pixel_565,
	output logic                            row_end,
	output logic                            frame_end
);
	import fsd_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int RGB_W = $bits(fsd_rgb_t);
	localparam int FLG_W = $bits(fsd_flags_t);
	localparam int QW = XW + FLG_W + RGB_W;

	logic          push;
	logic          full;
	logic          nonempty;
	logic          pop;
	logic [XW-1:0] front_col;
	fsd_flags_t    front_flags;
	fsd_rgb_t      front_rgb;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;
	logic [XW-1:0] head_col;
	fsd_flags_t    head_flags;
	fsd_rgb_t      head_rgb;

	// front: classify each pixel by its place in the frame
	fsd_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_valid(pix_valid),
		.full     (full),
		.push     (push),
		.col      (front_col),
		.flags    (front_flags)
	);

	assign pix_stall = full;

	always_comb begin
		front_rgb.red   = red_in;
		front_rgb.green = green_in;
		front_rgb.blue  = blue_in;
		q_wdata = {front_col, front_flags, front_rgb};
	end

	// queue decouples intake from the diffusion pipeline
	fsd_queue #(
		.DW(QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wdata   (q_wdata),
		.pop     (pop),
		.full    (full),
		.nonempty(nonempty),
		.rdata   (q_rdata)
	);

	assign {head_col, head_flags, head_rgb} = q_rdata;

	// back: line buffer, error diffusion, output word register
	fsd_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(nonempty),
		.head_col  (head_col),
		.head_flags(head_flags),
		.head_rgb  (head_rgb),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.pixel_565 (pixel_565),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

endmodule

`default_nettype wire

// File: sim/fsd_dither_checker.sv
// Scoreboard for the RGB565 dither: watches the config port and both word channels,
// predicts each output word and compares it field by field. Depends on fsd_pkg.
module fsd_dither_checker #(
	parameter int MAX_COLS = 2048
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [fsd_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                       pix_valid,
	input  wire logic                       pix_stall,
	input  wire logic [7:0]                 red_in,
	input  wire logic [7:0]                 green_in,
	input  wire logic [7:0]                 blue_in,
	input  wire logic                       res_valid,
	input  wire logic                       res_stall,
	input  wire logic [15:0]                pixel_565,
	input  wire logic                       row_end,
	input  wire logic                       frame_end,
	output int                              mismatches,
	output int                              outstanding,
	output int                              words_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import fsd_pkg::*;

	typedef struct packed {
		logic [15:0] pixel;
		logic        row_end;
		logic        frame_end;
	} dither_word_t;

	dither_word_t         dithered_words [$];
	logic [WIDTH_W-1:0]   width_reg;
	logic [HEIGHT_W-1:0]  height_reg;
	fsd_err_t             below_err [3][MAX_COLS];
	fsd_err_t             right_err [3];
	fsd_err_t             carry_near [3];
	fsd_err_t             carry_far [3];
	int unsigned          col;
	int unsigned          row;
	int                   fail_tally;
	int                   seen;

	// floor(e * k / 16)
	function automatic longint sixteenths(input longint e, input int k);
		return (e * k) >>> 4;
	endfunction

	task automatic clear_state;
		int c;
		int i;
		width_reg  = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		for (c = 0; c < 3; c++) begin
			for (i = 0; i < MAX_COLS; i++)
				below_err[c][i] = '0;
			right_err[c]  = '0;
			carry_near[c] = '0;
			carry_far[c]  = '0;
		end
		col = 0;
		row = 0;
		dithered_words.delete();
		fail_tally = 0;
		seen = 0;
	endtask

	task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int unsigned  w;
		int unsigned  h;
		int unsigned  x;
		logic         first_row;
		logic         last_row;
		logic         last_col;
		logic [7:0]   src [3];
		longint       level;
		longint       top;
		longint       quant;
		longint       qerr;
		longint       s3;
		longint       s5;
		longint       s1;
		longint       codes [3];
		int           c;
		dither_word_t word;
		src[0] = r;
		src[1] = g;
		src[2] = b;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > MAX_COLS) w = MAX_COLS;
		h = height_reg;
		if (h < 1) h = 1;
		x = (col >= MAX_COLS) ? MAX_COLS - 1 : col;
		first_row = (row == 0);
		last_row  = (row + 1 >= h);
		last_col  = (x + 1 >= w);
		for (c = 0; c < 3; c++) begin
			level = (longint'(src[c]) << FRAC_BITS) + longint'(right_err[c]);
			if (!first_row)
				level += longint'(below_err[c][x]);
			if (level > 64'sd33554431) level = 64'sd33554431;
			if (level < -64'sd33554432) level = -64'sd33554432;
			top = longint'((c == 1) ? 8'hfc : 8'hf8) << FRAC_BITS;
			if (level > top)
				quant = top;
			else if (level > 0)
				quant = level & top;
			else
				quant = 0;
			qerr = level - quant;
			codes[c] = quant >>> (FRAC_BITS + ((c == 1) ? 2 : 3));
			right_err[c] = last_col ? '0 : fsd_err_t'(sixteenths(qerr, 7));
			if (!last_row) begin
				s3 = sixteenths(qerr, 3);
				s5 = sixteenths(qerr, 5);
				s1 = sixteenths(qerr, 1);
				if (x > 0)
					below_err[c][x-1] = fsd_err_t'(longint'(carry_near[c]) + s3);
				carry_near[c] = fsd_err_t'(longint'(carry_far[c]) + s5);
				carry_far[c]  = fsd_err_t'(s1);
				if (last_col)
					below_err[c][x] = carry_near[c];
			end
			if (last_col) begin
				carry_near[c] = '0;
				carry_far[c]  = '0;
			end
		end
		word.pixel     = 16'((codes[0] << 11) | (codes[1] << 5) | codes[2]);
		word.row_end   = last_col;
		word.frame_end = last_col && last_row;
		dithered_words.push_back(word);
		if (last_col) begin
			col = 0;
			row = last_row ? 0 : ((row + 1) & 32'hffff);
		end else begin
			col = x + 1;
		end
	endtask

	task automatic check_word;
		dither_word_t want;
		seen++;
		if (dithered_words.size() == 0) begin
			$display("%0t: unexpected word: expected none, actual pixel %h row_end %b frame_end %b",
				$time, pixel_565, row_end, frame_end);
			fail_tally++;
		end else begin
			want = dithered_words.pop_front();
			if (pixel_565 !== want.pixel) begin
				$display("%0t: pixel_565 expected %h actual %h", $time, want.pixel, pixel_565);
				fail_tally++;
			end
			if (row_end !== want.row_end) begin
				$display("%0t: row_end expected %b actual %b", $time, want.row_end, row_end);
				fail_tally++;
			end
			if (frame_end !== want.frame_end) begin
				$display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
					frame_end);
				fail_tally++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (cfg_we) begin
				if (fsd_reg_t'(cfg_index) == REG_IMAGE_WIDTH)
					width_reg = cfg_data[WIDTH_W-1:0];
				else
					height_reg = cfg_data[HEIGHT_W-1:0];
			end
			// compare before predicting so a word never meets its own prediction
			if (res_valid && !res_stall)
				check_word();
			if (pix_valid && !pix_stall)
				predict_pixel(red_in, green_in, blue_in);
		end
		mismatches    <= fail_tally;
		outstanding   <= dithered_words.size();
		words_checked <= seen;
	end

endmodule

// File: sim/tb_floyd_steinberg_rgb565_dither.sv
// Testbench top for the Floyd-Steinberg RGB565 dither: drives pixels and geometry,
// randomizes both handshakes and reports the verdict. Needs fsd_pkg, the dither RTL
// and fsd_dither_checker.
module tb_floyd_steinberg_rgb565_dither;
	timeunit 1ns;
	timeprecision 1ps;
	import fsd_pkg::*;

	localparam int RANDOM_PIXELS = 950;
	localparam int CHOKE_CYCLES  = 80;   // long receiver hold-off
	localparam int DRAIN_CYCLES  = 6;    // settling clocks after the last word has come back

	typedef enum int {
		STYLE_NOISE,
		STYLE_RAMP,
		STYLE_EDGES,
		STYLE_FLAT
	} pixel_style_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic              cfg_index = 1'b0;
	logic [CFG_W-1:0]  cfg_data  = '0;
	logic              pix_valid = 1'b0;
	logic              pix_stall;
	logic [7:0]        red_in    = '0;
	logic [7:0]        green_in  = '0;
	logic [7:0]        blue_in   = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [15:0]       pixel_565;
	logic              row_end;
	logic              frame_end;

	int mismatches;
	int outstanding;
	int words_checked;

	// handshake behavior shared between the sender and the receiver process
	bit send_lazy = 1'b1;
	bit take_lazy = 1'b1;
	bit choke_req = 1'b0;
	bit choke_on  = 1'b0;

	int frames_sent;
	int geometry_writes;
	int random_pixels;
	int choke_frames;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	floyd_steinberg_rgb565_dither DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.pixel_565 (pixel_565),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

	fsd_dither_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.red_in        (red_in),
		.green_in      (green_in),
		.blue_in       (blue_in),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.pixel_565     (pixel_565),
		.row_end       (row_end),
		.frame_end     (frame_end),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.words_checked (words_checked)
	);

	// Offer one pixel word after a random gap and return at the edge that took it.
	// Valid stays high across back-to-back words; the payload only changes once the
	// previous word has gone. During a receiver choke the sender never idles, so the
	// input queue fills and pix_stall has to rise.
	task automatic send_pixel(input fsd_rgb_t px);
		int gap;
		gap = (send_lazy && !choke_on) ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red_in    <= px.red;
		green_in  <= px.green;
		blue_in   <= px.blue;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
	endtask

	// Drop valid and wait until every predicted word has come back, plus a few
	// clocks so the pipeline is really empty before the next geometry write.
	task automatic drain;
		pix_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Both registers, one write each on consecutive clocks; only called when idle.
	task automatic set_geometry(input int w, input int h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data  <= CFG_W'(h);
		@(posedge clk);
		cfg_we    <= 1'b0;
		geometry_writes += 2;
	endtask

	// Levels that sit on or next to quantizer steps, plus the rails.
	function automatic logic [7:0] edge_level();
		case ($urandom_range(0, 4))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(0, 31) * 8 + (($urandom_range(0, 1) != 0) ? 7 : 0));
			3: return 8'($urandom_range(0, 63) * 4 + (($urandom_range(0, 1) != 0) ? 3 : 0));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic fsd_rgb_t make_pixel(input pixel_style_t style, input int x, input int y,
		input logic [7:0] tone);
		fsd_rgb_t px;
		case (style)
			STYLE_RAMP: begin
				px.red   = 8'(x * 9 + y * 3 + $urandom_range(0, 3));
				px.green = 8'(x * 5 + y * 11 + $urandom_range(0, 1));
				px.blue  = 8'(255 - x * 7 - y - $urandom_range(0, 2));
			end
			STYLE_EDGES: begin
				px.red   = edge_level();
				px.green = edge_level();
				px.blue  = edge_level();
			end
			STYLE_FLAT: begin
				px = {tone, tone, tone};
			end
			default: begin
				px = fsd_rgb_t'($urandom);
			end
		endcase
		return px;
	endfunction

	// One complete frame in raster order, so every buffered column is written by a
	// row before the next row reads it.
	task automatic send_frame(input int w, input int h);
		pixel_style_t style;
		logic [7:0]   tone;
		int           x;
		int           y;
		style = pixel_style_t'($urandom_range(0, 3));
		tone  = 8'($urandom);
		for (y = 0; y < h; y++)
			for (x = 0; x < w; x++)
				send_pixel(make_pixel(style, x, y, tone));
		frames_sent++;
	endtask

	// Receiver: random stall before each word, or one long hold-off on request.
	initial begin : receiver
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (choke_req) begin
				choke_req = 1'b0;
				choke_on  = 1'b1;
				res_stall <= 1'b1;
				repeat (CHOKE_CYCLES) @(posedge clk);
				choke_on  = 1'b0;
				res_stall <= 1'b0;
			end else begin
				gap = take_lazy ? $urandom_range(0, 18) : 0;
				if (gap > 0) begin
					res_stall <= 1'b1;
					repeat (gap) @(posedge clk);
					res_stall <= 1'b0;
				end
			end
			do @(posedge clk); while (!res_valid);
		end
	end

	initial begin : stimulus
		int w;
		int h;
		int pick;
		frames_sent     = 0;
		geometry_writes = 0;
		random_pixels   = 0;
		choke_frames    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry (640 wide): two words of row 0, then shrink the width to 3
		// mid-row. Column 2 ends the row, and row 1 is the last row and reads the
		// errors that row 0 left in the line buffer.
		send_pixel({8'd0, 8'd0, 8'd0});
		send_pixel({8'd255, 8'd255, 8'd255});
		drain();
		set_geometry(3, 2);
		send_pixel({8'd17, 8'd200, 8'd99});
		send_pixel({8'd255, 8'd0, 8'd255});
		send_pixel({8'd7, 8'd3, 8'd7});
		send_pixel({8'd128, 8'd128, 8'd128});
		drain();

		// 3x2 frame from the origin: rails, values just below the first code step
		// and values right on it.
		send_pixel({8'd255, 8'd255, 8'd255});
		send_pixel({8'd0, 8'd0, 8'd0});
		send_pixel({8'd4, 8'd2, 8'd4});
		send_pixel({8'd7, 8'd3, 8'd7});
		send_pixel({8'd8, 8'd4, 8'd8});
		send_pixel({8'd248, 8'd252, 8'd248});
		drain();

		// single-pixel frame: every word ends both row and frame
		set_geometry(1, 1);
		send_pixel({8'd200, 8'd100, 8'd50});
		drain();

		// width register at its top (clamped), height 0 counted as one row; then width 0
		// ends the row at the current column
		set_geometry(4095, 0);
		repeat (6) send_pixel(fsd_rgb_t'($urandom));
		drain();
		set_geometry(0, 0);
		send_pixel(fsd_rgb_t'($urandom));
		drain();

		// exactly the buffer width, cut short the same way
		set_geometry(2048, 1);
		repeat (3) send_pixel(fsd_rgb_t'($urandom));
		drain();
		set_geometry(1, 1);
		send_pixel(fsd_rgb_t'($urandom));
		drain();

		// tallest frame: a one-column strip, then the height drops to end it
		set_geometry(1, 65535);
		repeat (4) send_pixel(fsd_rgb_t'($urandom));
		drain();
		set_geometry(1, 2);
		send_pixel(fsd_rgb_t'($urandom));
		drain();

		// Random frames, mostly small and narrow; narrow ones exercise the slow path
		// where a row must wait for the line buffer write of the row above.
		while (random_pixels < RANDOM_PIXELS) begin
			pick = $urandom_range(0, 19);
			if (frames_sent == 2 || frames_sent == 12) begin
				// back-pressure frame: the receiver holds off for a long stretch
				w = 12;
				h = 8;
				choke_req = 1'b1;
				choke_frames++;
			end else if (pick == 0) begin
				w = $urandom_range(64, 160);
				h = 2;
			end else if (pick == 1) begin
				w = 1;
				h = $urandom_range(1, 12);
			end else if (pick == 2) begin
				w = $urandom_range(2, 8);
				h = 1;
			end else begin
				w = $urandom_range(1, 24);
				h = $urandom_range(1, 8);
			end
			send_lazy = ($urandom_range(0, 3) != 0);
			take_lazy = ($urandom_range(0, 3) != 0);
			set_geometry(w, h);
			send_frame(w, h);
			random_pixels += w * h;
			drain();
		end

		$display("covered %0d random frames, %0d register writes, %0d words compared",
			frames_sent, geometry_writes, words_checked);
		$display("with %0d long receiver hold-offs that filled the input queue", choke_frames);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin : watchdog
		#8ms;
		$display("timeout with %0d words still outstanding", outstanding);
		$display("status: fail");
		$finish;
	end

endmodule
